[rtl/core/mean_pool_l2_normalize_core_defines.svh]
// Assertion macros shared by the mean-pool / L2-normalise checker.
// No dependencies.
`ifndef MEAN_POOL_L2_NORMALIZE_CORE_DEFINES_SVH
`define MEAN_POOL_L2_NORMALIZE_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MPL_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define MPL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[rtl/core/mpl2n_pkg.sv]
// Types and constants for the mean-pool / L2-normalise core.
// No dependencies.
`timescale 1ns / 1ps
package mpl2n_pkg;
    localparam int SUM_W  = 26;
    localparam int COMP_W = 16;
    localparam int IDX_W  = 6;
    localparam int DIM_W  = 7;
    localparam int SS_W   = 64;
    localparam int ROOT_W = 32;
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 26'sh1FFFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 26'sh2000000;
endpackage

[rtl/core/mean_pool_l2_normalize_core.sv]
// Mean-pool and L2-normalise core: components enter one request per cycle
// while in the input state with no output pending; a valid vector's last component
// starts a walk through staging/sums RAMs (input stalled meanwhile).
// Finish: sum-of-squares walk, root, then per output a read, a serial restoring
// divide and a hand-off, plus any output stall.
// Sync active-low reset clears control and the sums RAM by valid bits; no staging reset.
`timescale 1ns / 1ps
module mean_pool_l2_normalize_core #(
    parameter int MAX_DIM     = 64,
    parameter int MAX_VECTORS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // component[15:0]
    input  logic        s_axis_tuser,  // operation
    input  logic        s_axis_tlast,  // last_component
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // normalized[15:0], index[21:16], pad
    output logic        m_axis_tuser,  // empty_res
    output logic        m_axis_tlast,  // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data     // dimension
);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_VECTORS + 1) + 1;
    localparam int SW = mpl2n_pkg::SUM_W;

    typedef enum logic [3:0] {
        ST_IN, ST_ACC, ST_SQ, ST_SQ_END, ST_ROOT, ST_RD, ST_DIV, ST_OUT
    } t_state;

    t_state r_state;
    logic [mpl2n_pkg::DIM_W-1:0] r_dim;
    logic [6:0]  r_pos;
    logic        r_bad;
    logic [CW-1:0] r_cnt;
    logic [MAX_DIM-1:0] r_valid;   // sums entry has been written since the last clear

    // memories
    logic [15:0] r_stage [MAX_DIM];
    logic signed [SW-1:0] r_sums [MAX_DIM];
    logic [15:0] r_st_q;
    logic signed [SW-1:0] r_sm_q;
    logic        r_sm_v;

    // walk
    logic [6:0]  r_wi;      // issued read address
    logic [6:0]  r_wj;      // address of data now in r_*_q
    logic        r_wv;      // r_*_q valid during walk
    logic [mpl2n_pkg::SS_W-1:0] r_ss;
    logic [mpl2n_pkg::SS_W-1:0] r_rx;
    logic [mpl2n_pkg::SS_W-1:0] r_rres;
    logic [mpl2n_pkg::SS_W-1:0] r_rbit;
    logic [mpl2n_pkg::ROOT_W-1:0] r_root;
    // divide
    logic [SW+15:0] r_num;
    logic [SW+16:0] r_rem;
    logic [5:0]  r_dstep;
    logic        r_neg;
    logic [AW:0] r_oi;
    logic [6:0]  r_end;
    logic [23:0] r_otd;
    logic        r_oe, r_ol, r_ov;

    logic [6:0]  w_dimc;
    logic        w_acc;
    logic [AW-1:0] w_ra;
    logic signed [SW-1:0] w_s, w_add;
    logic signed [SW:0] w_sum;
    logic [SW-1:0] w_mag;
    logic [mpl2n_pkg::SS_W-1:0] w_sq;
    logic [SW+16:0] w_trial;

    assign w_dimc = (r_dim > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_dim;
    assign s_axis_tready = (r_state == ST_IN) && !r_ov;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_otd;
    assign m_axis_tuser  = r_oe;
    assign m_axis_tlast  = r_ol;

    assign w_s   = r_sm_v ? r_sm_q : '0;
    assign w_add = SW'(signed'(r_st_q));
    assign w_sum = {w_s[SW-1], w_s} + {w_add[SW-1], w_add};
    assign w_mag = w_s[SW-1] ? SW'(-w_s) : w_s;
    assign w_sq  = 64'(w_mag) * 64'(w_mag);
    assign w_trial = {r_rem[SW+15:0], r_num[SW+15]} - {(SW+17-32)'(0), r_root};

    assign w_acc = !r_bad && (r_dim >= 7'd1)
                 && (r_dim <= 7'(MAX_DIM)) && ((r_pos + 7'd1) == r_dim)
                 && (r_cnt < CW'(MAX_VECTORS)) && (r_pos < 7'(MAX_DIM));
    assign w_ra = r_wi[AW-1:0];

    // memory reads (registered)
    always_ff @(posedge i_clk) begin
        r_st_q <= r_stage[w_ra];
        r_sm_q <= r_sums[w_ra];
        r_sm_v <= r_valid[w_ra];
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == mpl2n_pkg::OP_ADD
            && r_pos < 7'(MAX_DIM))
            r_stage[r_pos[AW-1:0]] <= s_axis_tdata;
        if (r_state == ST_ACC && r_wv) begin
            if (w_sum > (SW+1)'(mpl2n_pkg::SUM_MAX))
                r_sums[r_wj[AW-1:0]] <= mpl2n_pkg::SUM_MAX;
            else if (w_sum < (SW+1)'(mpl2n_pkg::SUM_MIN))
                r_sums[r_wj[AW-1:0]] <= mpl2n_pkg::SUM_MIN;
            else
                r_sums[r_wj[AW-1:0]] <= w_sum[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IN; r_dim <= 7'd64; r_pos <= '0; r_bad <= 1'b0;
            r_cnt <= '0; r_valid <= '0; r_ov <= 1'b0; r_wv <= 1'b0;
            r_wi <= '0; r_wj <= '0;
        end else begin
            if (i_cfg_valid) r_dim <= i_cfg_data;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            case (r_state)
                ST_IN: begin
                    r_wi <= '0; r_wv <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (s_axis_tuser == mpl2n_pkg::OP_ADD) begin
                            if (s_axis_tlast) begin
                                r_pos <= '0; r_bad <= 1'b0;
                                if (w_acc) begin
                                    r_cnt <= r_cnt + CW'(1);
                                    r_state <= ST_ACC;
                                end
                            end else begin
                                if (r_pos >= 7'(MAX_DIM)) r_bad <= 1'b1;
                                r_pos <= (r_pos < 7'd127) ? r_pos + 7'd1 : r_pos;
                            end
                        end else begin
                            r_ss <= '0;
                            if (r_cnt == '0 || w_dimc == '0) begin
                                r_otd <= '0; r_oe <= 1'b1; r_ol <= 1'b1;
                                r_ov <= 1'b1;
                                r_pos <= '0; r_bad <= 1'b0;
                                r_cnt <= '0; r_valid <= '0;
                            end else begin
                                r_state <= ST_SQ;
                            end
                        end
                    end
                end
                ST_ACC: begin
                    r_wj <= r_wi; r_wv <= (r_wi < r_dim);
                    if (r_wi < r_dim) r_wi <= r_wi + 7'd1;
                    if (r_wv) r_valid[r_wj[AW-1:0]] <= 1'b1;
                    if (r_wi >= r_dim && !r_wv) r_state <= ST_IN;
                end
                ST_SQ: begin
                    r_wj <= r_wi; r_wv <= (r_wi < w_dimc);
                    if (r_wi < w_dimc) r_wi <= r_wi + 7'd1;
                    if (r_wv) r_ss <= r_ss + w_sq;
                    if (r_wi >= w_dimc && !r_wv) r_state <= ST_SQ_END;
                end
                ST_SQ_END: begin
                    r_rx <= r_ss; r_rres <= '0;
                    r_rbit <= 64'h4000_0000_0000_0000;
                    r_pos <= '0; r_bad <= 1'b0;
                    if (r_ss == '0) begin
                        r_otd <= '0; r_oe <= 1'b1; r_ol <= 1'b1; r_ov <= 1'b1;
                        r_cnt <= '0; r_valid <= '0; r_state <= ST_IN;
                    end else r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (r_rbit == '0) begin
                        r_root <= r_rres[31:0]; r_oi <= '0; r_wi <= '0;
                        r_end <= w_dimc; r_state <= ST_RD;
                    end else begin
                        if (r_rx >= r_rres + r_rbit) begin
                            r_rx <= r_rx - (r_rres + r_rbit);
                            r_rres <= (r_rres >> 1) + r_rbit;
                        end else r_rres <= r_rres >> 1;
                        r_rbit <= r_rbit >> 2;
                    end
                end
                ST_RD: begin
                    // r_wi was set on entry for r_oi; r_wv marks when its read data is in r_*_q
                    if (r_wv) begin
                        r_neg <= w_s[SW-1];
                        r_num <= {w_mag, 16'h0} >> 1;
                        r_rem <= '0; r_dstep <= '0; r_wv <= 1'b0;
                        r_state <= ST_DIV;
                    end else r_wv <= 1'b1;
                end
                ST_DIV: begin
                    if (r_dstep == 6'(SW + 16)) begin
                        if (!r_ov) begin
                            if (r_neg)
                                r_otd[15:0] <= (r_num > 42'd32768) ? 16'h8000
                                             : 16'(-r_num[15:0]);
                            else
                                r_otd[15:0] <= (r_num > 42'd32767) ? 16'h7FFF
                                             : r_num[15:0];
                            r_otd[23:16] <= 8'(r_oi);
                            r_oe <= 1'b0;
                            r_ol <= (7'(r_oi) + 7'd1 == r_end);
                            r_ov <= 1'b1;
                            r_state <= ST_OUT;
                        end
                    end else begin
                        if (!w_trial[SW+16]) r_rem <= w_trial;
                        else r_rem <= {r_rem[SW+15:0], r_num[SW+15]};
                        r_num <= {r_num[SW+14:0], !w_trial[SW+16]};
                        r_dstep <= r_dstep + 6'd1;
                    end
                end
                ST_OUT: begin
                    if (7'(r_oi) + 7'd1 == r_end) begin
                        r_cnt <= '0; r_valid <= '0; r_state <= ST_IN;
                    end else begin
                        r_oi <= r_oi + 1'b1;
                        r_wi <= 7'(r_oi) + 7'd1; r_wv <= 1'b0;
                        r_state <= ST_RD;
                    end
                end
                default: r_state <= ST_IN;
            endcase
        end
    end
endmodule

[rtl/core/mean_pool_l2_normalize_core_chk.sv]
// Port-level checker for the mean-pool / L2-normalise core, bound to it.
// Depends on mean_pool_l2_normalize_core_defines.svh.
`timescale 1ns / 1ps
`include "mean_pool_l2_normalize_core_defines.svh"
module mean_pool_l2_normalize_core_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    `MPL_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `MPL_ASSERT_IMPL(a_empty_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast && m_axis_tdata == 24'd0)
    `MPL_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
endmodule

bind mean_pool_l2_normalize_core mean_pool_l2_normalize_core_chk u_chk (.*);
